// ===== src/orq_pkg.sv =====
package orq_pkg;

  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DROP_W   = 9;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 9;
  localparam int unsigned OCC_W    = 9;

  localparam int unsigned POS_CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int unsigned DROP_CMP_W = (DROP_W > CNT_W) ? DROP_W : CNT_W;
  localparam int unsigned SUM_W      = CNT_W + 2;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_DROP  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WRITE = 3'd4,
    CMD_FIND  = 3'd5,
    CMD_COUNT = 3'd6,
    CMD_CLEAR = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_BAD_DROP  = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SEEK = 2'd1,
    S_SCAN = 2'd2,
    S_DONE = 2'd3
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctrl_t;

endpackage

// ===== src/orq_if.sv =====
interface orq_req_if;
  logic                        valid;
  logic                        ready;
  logic [orq_pkg::CMD_W-1:0]   cmd;
  logic [orq_pkg::POS_W-1:0]   position;
  logic [orq_pkg::VALUE_W-1:0] value;
  logic [orq_pkg::DROP_W-1:0]  drop_count;

  modport source (output valid, cmd, position, value, drop_count, input ready);
  modport sink   (input valid, cmd, position, value, drop_count, output ready);
endinterface

interface orq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [orq_pkg::STATUS_W-1:0] status;
  logic [orq_pkg::VALUE_W-1:0]  read_value;
  logic [orq_pkg::FOUND_W-1:0]  found_position;
  logic [orq_pkg::OCC_W-1:0]    occupancy;
  logic                         overwrote;

  modport source (output valid, status, read_value, found_position, occupancy, overwrote,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, occupancy, overwrote,
                  output ready);
endinterface

// ===== src/orq_cell.sv =====
module orq_cell (
  input  logic                 clk_i,
  input  orq_pkg::chain_ctrl_t ctrl_i,
  input  orq_pkg::data_t       shift_data_i,
  input  orq_pkg::data_t       load_data_i,
  output orq_pkg::data_t       data_o
);

  orq_pkg::data_t data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      data_q <= load_data_i;
    end else if (ctrl_i.shift) begin
      data_q <= shift_data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== src/orq_chain.sv =====
module orq_chain (
  input  logic                 clk_i,
  input  orq_pkg::chain_ctrl_t ctrl_i,
  input  orq_pkg::data_t       load_data_i,
  output orq_pkg::data_t       head_data_o
);

  orq_pkg::data_t cell_data [orq_pkg::CAPACITY];

  for (genvar i = 0; i < orq_pkg::CAPACITY; i++) begin : g_cell
    orq_pkg::chain_ctrl_t cell_ctrl;

    // only the head cell takes a new word
    assign cell_ctrl.shift = ctrl_i.shift;
    assign cell_ctrl.load  = (i == 0) ? ctrl_i.load : 1'b0;

    orq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .shift_data_i (cell_data[(i + 1) % orq_pkg::CAPACITY]),
      .load_data_i  (load_data_i),
      .data_o       (cell_data[i])
    );
  end

  assign head_data_o = cell_data[0];

endmodule

// ===== src/overwriting_ring_queue_core.sv =====
// Overwriting ring queue of CAPACITY words held in a closed ring of cells that
// rotates one place per cycle while a command seeks or scans; all access goes through
// the head cell. Each command is accepted, then the ring rotates until its slot is at
// the head, where the command acts on it, and the result is then handed to the output
// register. Drop, clear and rejected commands go straight to the output register;
// push, pop, read and write seek their slot first, and find and count seek to the
// oldest word and then scan the words held, find stopping at the first match.
// One command is worked on at a time; a new one is taken while the last result still
// waits in the output register.
module overwriting_ring_queue_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  orq_req_if.sink  req_i,
  orq_rsp_if.source rsp_o
);

  localparam orq_pkg::cnt_t CAP_CNT  = orq_pkg::CNT_W'(orq_pkg::CAPACITY);
  localparam orq_pkg::idx_t LAST_IDX = orq_pkg::IDX_W'(orq_pkg::CAPACITY - 1);
  localparam logic [orq_pkg::SUM_W-1:0] CAP_SUM = orq_pkg::SUM_W'(orq_pkg::CAPACITY);

  orq_pkg::state_e  state_q, state_d;
  orq_pkg::cnt_t    count_q, count_d;
  orq_pkg::idx_t    newest_q, newest_d;
  orq_pkg::idx_t    rot_q, rot_d;
  orq_pkg::idx_t    target_q, target_d;
  orq_pkg::cnt_t    idx_q, idx_d;
  orq_pkg::cmd_e    cmd_q, cmd_d;
  orq_pkg::data_t   key_q, key_d;
  orq_pkg::status_e status_q, status_d;
  orq_pkg::data_t   rd_q, rd_d;
  orq_pkg::cnt_t    found_q, found_d;
  logic             ovw_q, ovw_d;

  logic                       out_valid_q, out_valid_d;
  orq_pkg::status_e           out_status_q;
  orq_pkg::data_t             out_rd_q;
  orq_pkg::cnt_t              out_found_q;
  orq_pkg::cnt_t              out_occ_q;
  logic                       out_ovw_q;
  logic                       out_load;

  orq_pkg::chain_ctrl_t chain_ctrl;
  orq_pkg::data_t       head_data;

  orq_pkg::cmd_e cmd_in;
  orq_pkg::idx_t newest_inc;
  orq_pkg::idx_t rot_inc;
  orq_pkg::idx_t oldest_slot;
  orq_pkg::idx_t pos_slot;
  logic          empty;
  logic          pos_bad;
  logic          drop_bad;
  logic          hit;
  logic          last;

  logic [orq_pkg::SUM_W-1:0] base_sum;
  logic [orq_pkg::SUM_W-1:0] pos_sum;
  logic [orq_pkg::SUM_W-1:0] oldest_wrap;
  logic [orq_pkg::SUM_W-1:0] pos_wrap;

  orq_chain u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (chain_ctrl),
    .load_data_i (key_q),
    .head_data_o (head_data)
  );

  assign cmd_in     = orq_pkg::cmd_e'(req_i.cmd);
  assign newest_inc = (newest_q == LAST_IDX) ? '0 : newest_q + orq_pkg::IDX_W'(1);
  assign rot_inc    = (rot_q == LAST_IDX) ? '0 : rot_q + orq_pkg::IDX_W'(1);
  assign empty      = (count_q == '0);

  // slot of the oldest word: newest + CAPACITY - count + 1, at most twice CAPACITY
  assign base_sum    = orq_pkg::SUM_W'(newest_q) + CAP_SUM - orq_pkg::SUM_W'(count_q)
                     + orq_pkg::SUM_W'(1);
  assign oldest_wrap = (base_sum >= CAP_SUM) ? base_sum - CAP_SUM : base_sum;
  assign oldest_slot = oldest_wrap[orq_pkg::IDX_W-1:0];

  assign pos_sum  = oldest_wrap + orq_pkg::SUM_W'(req_i.position);
  assign pos_wrap = (pos_sum >= CAP_SUM) ? pos_sum - CAP_SUM : pos_sum;
  assign pos_slot = pos_wrap[orq_pkg::IDX_W-1:0];

  assign pos_bad  = orq_pkg::POS_CMP_W'(req_i.position) >= orq_pkg::POS_CMP_W'(count_q);
  assign drop_bad = (req_i.drop_count == '0)
                 || (orq_pkg::DROP_CMP_W'(req_i.drop_count) > orq_pkg::DROP_CMP_W'(count_q));

  assign hit  = (head_data == key_q);
  assign last = (idx_q == count_q - orq_pkg::CNT_W'(1));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    newest_d   = newest_q;
    target_d   = target_q;
    idx_d      = idx_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    status_d   = status_q;
    rd_d       = rd_q;
    found_d    = found_q;
    ovw_d      = ovw_q;
    chain_ctrl = '0;
    out_load   = 1'b0;

    case (state_q)
      orq_pkg::S_IDLE: begin
        if (req_i.valid) begin
          cmd_d    = cmd_in;
          key_d    = orq_pkg::DATA_WIDTH'(req_i.value);
          status_d = orq_pkg::STAT_OK;
          rd_d     = '0;
          found_d  = '0;
          ovw_d    = 1'b0;
          idx_d    = '0;
          state_d  = orq_pkg::S_DONE;
          case (cmd_in)
            orq_pkg::CMD_PUSH: begin
              if (!empty) begin
                newest_d = newest_inc;
              end
              if (count_q == CAP_CNT) begin
                ovw_d = 1'b1;
              end else begin
                count_d = count_q + orq_pkg::CNT_W'(1);
              end
              target_d = empty ? newest_q : newest_inc;
              state_d  = orq_pkg::S_SEEK;
            end
            orq_pkg::CMD_POP: begin
              if (empty) begin
                status_d = orq_pkg::STAT_RANGE;
              end else begin
                target_d = oldest_slot;
                count_d  = count_q - orq_pkg::CNT_W'(1);
                state_d  = orq_pkg::S_SEEK;
              end
            end
            orq_pkg::CMD_DROP: begin
              if (drop_bad) begin
                status_d = orq_pkg::STAT_BAD_DROP;
              end else begin
                count_d = count_q - orq_pkg::CNT_W'(req_i.drop_count);
              end
            end
            orq_pkg::CMD_READ, orq_pkg::CMD_WRITE: begin
              if (pos_bad) begin
                status_d = orq_pkg::STAT_RANGE;
              end else begin
                target_d = pos_slot;
                state_d  = orq_pkg::S_SEEK;
              end
            end
            orq_pkg::CMD_FIND, orq_pkg::CMD_COUNT: begin
              if (empty) begin
                status_d = orq_pkg::STAT_RANGE;
              end else begin
                target_d = oldest_slot;
                state_d  = orq_pkg::S_SEEK;
              end
            end
            orq_pkg::CMD_CLEAR: begin
              count_d  = '0;
              newest_d = '0;
            end
            default: ;
          endcase
        end
      end

      orq_pkg::S_SEEK: begin
        if (rot_q == target_q) begin
          case (cmd_q)
            orq_pkg::CMD_PUSH, orq_pkg::CMD_WRITE: begin
              chain_ctrl.load = 1'b1;
              state_d         = orq_pkg::S_DONE;
            end
            orq_pkg::CMD_POP, orq_pkg::CMD_READ: begin
              rd_d    = head_data;
              state_d = orq_pkg::S_DONE;
            end
            orq_pkg::CMD_FIND, orq_pkg::CMD_COUNT: begin
              state_d = orq_pkg::S_SCAN;
            end
            default: begin
              state_d = orq_pkg::S_DONE;
            end
          endcase
        end else begin
          chain_ctrl.shift = 1'b1;
        end
      end

      orq_pkg::S_SCAN: begin
        chain_ctrl.shift = 1'b1;
        idx_d            = idx_q + orq_pkg::CNT_W'(1);
        if (cmd_q == orq_pkg::CMD_FIND) begin
          if (hit) begin
            found_d  = idx_q;
            status_d = orq_pkg::STAT_OK;
            state_d  = orq_pkg::S_DONE;
          end else if (last) begin
            status_d = orq_pkg::STAT_NOT_FOUND;
            state_d  = orq_pkg::S_DONE;
          end
        end else begin
          found_d = found_q + orq_pkg::CNT_W'(hit);
          if (last) begin
            state_d = orq_pkg::S_DONE;
          end
        end
      end

      orq_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = orq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = orq_pkg::S_IDLE;
      end
    endcase

    rot_d       = chain_ctrl.shift ? rot_inc : rot_q;
    out_valid_d = out_load || (out_valid_q && !rsp_o.ready);
  end

  assign req_i.ready = (state_q == orq_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= orq_pkg::S_IDLE;
      count_q     <= '0;
      newest_q    <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      newest_q    <= newest_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    idx_q    <= idx_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    found_q  <= found_d;
    ovw_q    <= ovw_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_rd_q     <= rd_q;
      out_found_q  <= found_q;
      out_occ_q    <= count_q;
      out_ovw_q    <= ovw_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.read_value     = orq_pkg::VALUE_W'(out_rd_q);
  assign rsp_o.found_position = orq_pkg::FOUND_W'(out_found_q);
  assign rsp_o.occupancy      = orq_pkg::OCC_W'(out_occ_q);
  assign rsp_o.overwrote      = out_ovw_q;

endmodule
